// ===== rtl/mfs_pkg.sv =====
// shared types, constants and codes of the multilevel feedback scheduler
package mfs_pkg;

    localparam int LEVELS      = 3;
    localparam int QUEUE_DEPTH = 16;

    localparam int NUM_QUEUES = LEVELS + 1;
    localparam int LV_IW      = $clog2(NUM_QUEUES);
    localparam int QD_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W      = QD_W + 1;
    localparam int RAM_DEPTH  = NUM_QUEUES * QUEUE_DEPTH;
    localparam int RAM_AW     = $clog2(RAM_DEPTH);
    localparam int TOTAL_W    = $clog2(RAM_DEPTH + 1);

    localparam int TAG_W   = 16;
    localparam int TIME_W  = 16;
    localparam int LEVEL_W = 3;
    localparam int KIND_W  = 2;
    localparam int ERR_W   = 2;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REQUEUE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SELECT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd3;

    localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DEMOTE = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] elapsed;
        logic              finished;
    } cmd_t;

endpackage

// ===== rtl/mfs_ram.sv =====
// generic single-write, single-read ram with registered read data
module mfs_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mfs_front.sv =====
// front end: accepts requests, classifies them and queues them for the back end
module mfs_front import mfs_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [KIND_W-1:0] kind,
    input  logic [TAG_W-1:0]  task_tag,
    input  logic [TIME_W-1:0] service_time,
    input  logic [TIME_W-1:0] done_time,
    input  logic [TIME_W-1:0] elapsed_time,
    output cmd_t              cmd,
    output logic              cmd_valid,
    input  logic              cmd_pop
);

    cmd_t                entries_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg;
    logic [FIFO_AW-1:0]  wr_ptr_next;
    logic [FIFO_AW-1:0]  rd_ptr_reg;
    logic [FIFO_AW-1:0]  rd_ptr_next;
    logic [FIFO_CW-1:0]  count_reg;
    logic [FIFO_CW-1:0]  count_next;
    logic                accept;
    logic                pop;
    logic [TIME_W:0]     sum;
    cmd_t                incoming;

    // the finished test is settled here so the back end sees a single bit
    assign sum = {1'b0, done_time} + {1'b0, elapsed_time};

    always_comb
    begin
        incoming.kind     = kind;
        incoming.tag      = task_tag;
        incoming.elapsed  = elapsed_time;
        incoming.finished = (sum == {1'b0, service_time});
    end

    assign busy      = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign accept    = start && !busy;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (accept && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !accept)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entries_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

// ===== rtl/mfs_back.sv =====
// back end: ready queue bookkeeping, tag memory and result generation
module mfs_back import mfs_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  logic               cmd_valid,
    output logic               cmd_pop,
    output logic               done,
    output logic               found,
    output logic [TAG_W-1:0]   picked_tag,
    output logic [LEVEL_W-1:0] picked_level,
    output logic               keep_running,
    output logic               none_waiting,
    output logic [ERR_W-1:0]   error_code
);

    logic [QD_W-1:0]    heads_reg  [NUM_QUEUES];
    logic [QD_W-1:0]    heads_next [NUM_QUEUES];
    logic [CNT_W-1:0]   counts_reg  [NUM_QUEUES];
    logic [CNT_W-1:0]   counts_next [NUM_QUEUES];
    logic [LEVEL_W-1:0] cur_level_reg;
    logic [LEVEL_W-1:0] cur_level_next;
    logic               level_valid_reg;
    logic               level_valid_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;

    logic               done_reg;
    logic               found_reg;
    logic               found_next;
    logic [LEVEL_W-1:0] picked_level_reg;
    logic [LEVEL_W-1:0] picked_level_next;
    logic               keep_reg;
    logic               keep_next;
    logic               none_reg;
    logic [ERR_W-1:0]   err_reg;
    logic [ERR_W-1:0]   err_next;

    logic               any_waiting;
    logic [LEVEL_W-1:0] pick_lv;
    logic [LEVEL_W-1:0] tgt_lv;
    logic [LV_IW-1:0]   tgt_idx;
    logic [QD_W-1:0]    tgt_head;
    logic [CNT_W-1:0]   tgt_count;
    logic [SUM_W-1:0]   tail_sum;
    logic [QD_W-1:0]    tail;
    logic [QD_W-1:0]    head_inc;
    logic               tgt_full;
    logic               do_push;
    logic               do_pop;
    logic [RAM_AW-1:0]  wr_addr;
    logic [RAM_AW-1:0]  rd_addr;
    logic [RAM_AW-1:0]  tgt_base;
    logic [TAG_W-1:0]   rd_data;
    logic [TIME_W:0]    slice;

    assign cmd_pop = cmd_valid;

    // highest priority level holding a tag
    always_comb
    begin
        any_waiting = 1'b0;
        pick_lv     = '0;
        for (int lv = NUM_QUEUES - 1; lv >= 0; lv--)
        begin
            if (counts_reg[lv] != '0)
            begin
                any_waiting = 1'b1;
                pick_lv     = LEVEL_W'(lv);
            end
        end
    end

    always_comb
    begin
        case (cmd.kind)
            KIND_INSERT:  tgt_lv = '0;
            KIND_REQUEUE: tgt_lv = cur_level_reg + 1'b1;
            KIND_SELECT:  tgt_lv = pick_lv;
            default:      tgt_lv = '0;
        endcase
    end

    assign tgt_idx   = tgt_lv[LV_IW-1:0];
    assign tgt_head  = heads_reg[tgt_idx];
    assign tgt_count = counts_reg[tgt_idx];
    assign tgt_full  = (tgt_count == CNT_W'(QUEUE_DEPTH));
    assign tail_sum  = SUM_W'(tgt_head) + SUM_W'(tgt_count);
    assign tail      = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                       ? QD_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : QD_W'(tail_sum);
    assign head_inc  = (tgt_head == QD_W'(QUEUE_DEPTH - 1)) ? '0 : tgt_head + 1'b1;
    assign tgt_base  = RAM_AW'(tgt_lv) * RAM_AW'(QUEUE_DEPTH);
    assign wr_addr   = tgt_base + RAM_AW'(tail);
    assign rd_addr   = tgt_base + RAM_AW'(tgt_head);
    assign slice     = (TIME_W + 1)'(1) << cur_level_reg;

    always_comb
    begin
        do_push           = 1'b0;
        do_pop            = 1'b0;
        found_next        = 1'b0;
        picked_level_next = '0;
        keep_next         = 1'b0;
        err_next          = ERR_OK;
        cur_level_next    = cur_level_reg;
        level_valid_next  = level_valid_reg;
        if (cmd_valid)
        begin
            case (cmd.kind)
                KIND_INSERT:
                begin
                    if (tgt_full)
                    begin
                        err_next = ERR_FULL;
                    end
                    else
                    begin
                        do_push = 1'b1;
                    end
                end
                KIND_REQUEUE:
                begin
                    if (!level_valid_reg || cur_level_reg >= LEVEL_W'(LEVELS))
                    begin
                        err_next = ERR_DEMOTE;
                    end
                    else if (tgt_full)
                    begin
                        err_next = ERR_FULL;
                    end
                    else
                    begin
                        do_push = 1'b1;
                    end
                end
                KIND_SELECT:
                begin
                    if (any_waiting)
                    begin
                        do_pop            = 1'b1;
                        found_next        = 1'b1;
                        picked_level_next = pick_lv;
                        cur_level_next    = pick_lv;
                        level_valid_next  = 1'b1;
                    end
                end
                KIND_CHECK:
                begin
                    if (cmd.finished || !level_valid_reg)
                    begin
                        keep_next = 1'b0;
                    end
                    else if (cur_level_reg >= LEVEL_W'(LEVELS))
                    begin
                        keep_next = 1'b1;
                    end
                    else
                    begin
                        keep_next = ({1'b0, cmd.elapsed} < slice);
                    end
                end
                default:
                begin
                    err_next = ERR_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        total_next = total_reg;
        if (do_push)
        begin
            total_next = total_reg + 1'b1;
        end
        else if (do_pop)
        begin
            total_next = total_reg - 1'b1;
        end
        for (int lv = 0; lv < NUM_QUEUES; lv++)
        begin
            heads_next[lv]  = heads_reg[lv];
            counts_next[lv] = counts_reg[lv];
            if (tgt_idx == LV_IW'(lv))
            begin
                if (do_push)
                begin
                    counts_next[lv] = counts_reg[lv] + 1'b1;
                end
                else if (do_pop)
                begin
                    counts_next[lv] = counts_reg[lv] - 1'b1;
                    heads_next[lv]  = head_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int lv = 0; lv < NUM_QUEUES; lv++)
            begin
                heads_reg[lv]  <= '0;
                counts_reg[lv] <= '0;
            end
            cur_level_reg   <= '0;
            level_valid_reg <= 1'b0;
            total_reg       <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            for (int lv = 0; lv < NUM_QUEUES; lv++)
            begin
                heads_reg[lv]  <= heads_next[lv];
                counts_reg[lv] <= counts_next[lv];
            end
            cur_level_reg   <= cur_level_next;
            level_valid_reg <= level_valid_next;
            total_reg       <= total_next;
            done_reg        <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg        <= found_next;
        picked_level_reg <= picked_level_next;
        keep_reg         <= keep_next;
        none_reg         <= (total_next == '0);
        err_reg          <= err_next;
    end

    // tag read lands in the same cycle as the strobe
    mfs_ram #(
        .WIDTH (TAG_W),
        .DEPTH (RAM_DEPTH)
    ) u_tags (
        .clk   (clk),
        .we    (do_push),
        .waddr (wr_addr),
        .wdata (cmd.tag),
        .re    (do_pop),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign done         = done_reg;
    assign found        = found_reg;
    assign picked_tag   = found_reg ? rd_data : '0;
    assign picked_level = picked_level_reg;
    assign keep_running = keep_reg;
    assign none_waiting = none_reg;
    assign error_code   = err_reg;

endmodule

// ===== rtl/multilevel_feedback_scheduler.sv =====
// top level of the multilevel feedback scheduler: front end, request queue and back end
// done is registered in the back end from a request that has passed through the front-end queue register
// throughput: one request per cycle, the tag memory's registered read lines up with done
// busy stays low: the back end drains a request every cycle so the queue holds at most one
// the receiver cannot stall
// reset clears the request queue, queue heads and counts, waiting total and current level;
// the tag memory is not cleared
module multilevel_feedback_scheduler import mfs_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [KIND_W-1:0]  kind,
    input  logic [TAG_W-1:0]   task_tag,
    input  logic [TIME_W-1:0]  service_time,
    input  logic [TIME_W-1:0]  done_time,
    input  logic [TIME_W-1:0]  elapsed_time,
    output logic               done,
    output logic               found,
    output logic [TAG_W-1:0]   picked_tag,
    output logic [LEVEL_W-1:0] picked_level,
    output logic               keep_running,
    output logic               none_waiting,
    output logic [ERR_W-1:0]   error_code
);

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    mfs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .task_tag     (task_tag),
        .service_time (service_time),
        .done_time    (done_time),
        .elapsed_time (elapsed_time),
        .cmd          (cmd),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop)
    );

    mfs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop),
        .done         (done),
        .found        (found),
        .picked_tag   (picked_tag),
        .picked_level (picked_level),
        .keep_running (keep_running),
        .none_waiting (none_waiting),
        .error_code   (error_code)
    );

endmodule

// ===== verif/tb_multilevel_feedback_scheduler.sv =====
// self-checking testbench for the multilevel feedback scheduler
module tb_multilevel_feedback_scheduler;
    import mfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 650;
    localparam int QUIET_FROM     = 250;
    localparam int QUIET_TO       = 450;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 4;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] service;
        logic [TIME_W-1:0] done_so_far;
        logic [TIME_W-1:0] elapsed;
    } sched_req_t;

    typedef struct {
        logic               found;
        logic [TAG_W-1:0]   tag;
        logic [LEVEL_W-1:0] level;
        logic               keep;
        logic               none;
        logic [ERR_W-1:0]   err;
    } sched_result_t;

    typedef struct {
        sched_req_t    req;
        int            reps;
        bit            given;
        sched_result_t want;
    } script_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [KIND_W-1:0]  kind = KIND_INSERT;
    logic [TAG_W-1:0]   task_tag = '0;
    logic [TIME_W-1:0]  service_time = '0;
    logic [TIME_W-1:0]  done_time = '0;
    logic [TIME_W-1:0]  elapsed_time = '0;
    logic               done;
    logic               found;
    logic [TAG_W-1:0]   picked_tag;
    logic [LEVEL_W-1:0] picked_level;
    logic               keep_running;
    logic               none_waiting;
    logic [ERR_W-1:0]   error_code;

    // scheduler mirror
    logic [TAG_W-1:0] tag_store [NUM_QUEUES][QUEUE_DEPTH];
    int               head_ptr [NUM_QUEUES];
    int               occupancy [NUM_QUEUES];
    int               last_level;
    bit               last_level_ok;
    int               tags_waiting;

    sched_result_t pending_results [$];
    script_row_t   script [$];
    int            sent;
    int            mismatches;
    int            quiet_cycles;

    multilevel_feedback_scheduler DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .task_tag     (task_tag),
        .service_time (service_time),
        .done_time    (done_time),
        .elapsed_time (elapsed_time),
        .done         (done),
        .found        (found),
        .picked_tag   (picked_tag),
        .picked_level (picked_level),
        .keep_running (keep_running),
        .none_waiting (none_waiting),
        .error_code   (error_code)
    );

    always #6 clk = ~clk;

    function automatic logic [ERR_W-1:0] enqueue_tag(int lv, logic [TAG_W-1:0] tag);
        int slot;
        if (occupancy[lv] >= QUEUE_DEPTH)
            return ERR_FULL;
        slot = (head_ptr[lv] + occupancy[lv]) % QUEUE_DEPTH;
        tag_store[lv][slot] = tag;
        occupancy[lv]++;
        tags_waiting++;
        return ERR_OK;
    endfunction

    function automatic sched_result_t predict_step(sched_req_t r);
        sched_result_t res;
        logic [TIME_W:0] served;
        res = '{1'b0, '0, '0, 1'b0, 1'b0, ERR_OK};
        served = {1'b0, r.done_so_far} + {1'b0, r.elapsed};
        case (r.kind)
            KIND_INSERT:
                res.err = enqueue_tag(0, r.tag);
            KIND_REQUEUE:
                if (!last_level_ok || last_level >= LEVELS)
                    res.err = ERR_DEMOTE;
                else
                    res.err = enqueue_tag(last_level + 1, r.tag);
            KIND_SELECT:
                for (int lv = 0; lv < NUM_QUEUES; lv++)
                begin
                    if (occupancy[lv] != 0 && !res.found)
                    begin
                        res.tag = tag_store[lv][head_ptr[lv]];
                        head_ptr[lv] = (head_ptr[lv] + 1) % QUEUE_DEPTH;
                        occupancy[lv]--;
                        tags_waiting--;
                        res.found = 1'b1;
                        res.level = LEVEL_W'(lv);
                        last_level = lv;
                        last_level_ok = 1'b1;
                    end
                end
            default:
                // finished tasks stop; the lowest level has no time slice
                if (served == {1'b0, r.service} || !last_level_ok)
                    res.keep = 1'b0;
                else if (last_level >= LEVELS)
                    res.keep = 1'b1;
                else
                    res.keep = (r.elapsed < (TIME_W+1)'(1 << last_level));
        endcase
        res.none = (tags_waiting == 0);
        return res;
    endfunction

    task automatic issue(input sched_req_t r, input bit use_given, input sched_result_t given,
                         output sched_result_t model_out);
        int gap;
        gap = 0;
        if (!(sent >= QUIET_FROM && sent < QUIET_TO) && $urandom_range(0, 99) < 15)
            gap = $urandom_range(1, 2);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        kind         <= r.kind;
        task_tag     <= r.tag;
        service_time <= r.service;
        done_time    <= r.done_so_far;
        elapsed_time <= r.elapsed;
        do @(posedge clk); while (busy);
        model_out = predict_step(r);
        if (use_given)
            pending_results.insert(pending_results.size(), given);
        else
            pending_results.insert(pending_results.size(), model_out);
        sent++;
    endtask

    function automatic void row_pred(logic [KIND_W-1:0] k, logic [TAG_W-1:0] tag,
                                     logic [TIME_W-1:0] svc, logic [TIME_W-1:0] dn,
                                     logic [TIME_W-1:0] el, int reps);
        script_row_t row;
        row = '{'{k, tag, svc, dn, el}, reps, 1'b0,
                '{1'b0, '0, '0, 1'b0, 1'b0, ERR_OK}};
        script.insert(script.size(), row);
    endfunction

    function automatic void row_given(logic [KIND_W-1:0] k, logic [TAG_W-1:0] tag,
                                      logic [TIME_W-1:0] svc, logic [TIME_W-1:0] dn,
                                      logic [TIME_W-1:0] el, sched_result_t want);
        script_row_t row;
        row = '{'{k, tag, svc, dn, el}, 1, 1'b1, want};
        script.insert(script.size(), row);
    endfunction

    function automatic sched_req_t plain_request(logic [KIND_W-1:0] k, logic [TAG_W-1:0] tag);
        sched_req_t r;
        r = '{k, tag, 16'($urandom()), 16'($urandom()), 16'($urandom())};
        return r;
    endfunction

    // check with plausible times; now and then exactly finished
    function automatic sched_req_t dispatch_check();
        sched_req_t r;
        r = plain_request(KIND_CHECK, 16'($urandom()));
        r.service     = 16'($urandom_range(1, 40));
        r.done_so_far = 16'($urandom_range(0, r.service));
        r.elapsed     = 16'($urandom_range(0, 12));
        if ($urandom_range(0, 3) == 0)
            r.elapsed = r.service - r.done_so_far;
        return r;
    endfunction

    task automatic random_traffic(input int count);
        int            pick;
        int            burst;
        sched_req_t    r;
        sched_result_t unused;
        sched_result_t got;
        sched_result_t picked;
        unused = '{1'b0, '0, '0, 1'b0, 1'b0, ERR_OK};
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            burst = $urandom_range(1, 20);
            if (pick < 60)
            begin
                // dispatch: select, check, and demote or replace the task, and at times check once more
                issue(plain_request(KIND_SELECT, 16'($urandom())), 1'b0, unused, picked);
                issue(dispatch_check(), 1'b0, unused, got);
                if ($urandom_range(0, 3) != 0)
                    issue(plain_request(KIND_REQUEUE, picked.tag), 1'b0, unused, got);
                else
                    issue(plain_request(KIND_INSERT, 16'($urandom())), 1'b0, unused, got);
                if ($urandom_range(0, 1) == 0)
                    issue(dispatch_check(), 1'b0, unused, got);
            end
            else if (pick < 70)
                repeat (burst) issue(plain_request(KIND_INSERT, 16'($urandom())),
                                     1'b0, unused, got);
            else if (pick < 78)
                repeat (burst) issue(plain_request(KIND_REQUEUE, 16'($urandom())),
                                     1'b0, unused, got);
            else if (pick < 85)
                repeat (burst) issue(plain_request(KIND_SELECT, 16'($urandom())),
                                     1'b0, unused, got);
            else
            begin
                r = plain_request(KIND_W'($urandom_range(0, 3)), 16'($urandom()));
                if ($urandom_range(0, 9) == 0)
                    r.elapsed = r.service - r.done_so_far;
                issue(r, 1'b0, unused, got);
            end
        end
    endtask

    task automatic note_mismatch(input string fld, input int unsigned want,
                                 input int unsigned got);
        $display("[%0t] %s mismatch: expected %0h, actual %0h", $realtime, fld, want, got);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("[%0t] result with no request outstanding", $realtime);
                mismatches++;
            end
            else
            begin
                if (pending_results[0].found !== found)
                    note_mismatch("found", pending_results[0].found, found);
                if (pending_results[0].tag !== picked_tag)
                    note_mismatch("picked_tag", pending_results[0].tag, picked_tag);
                if (pending_results[0].level !== picked_level)
                    note_mismatch("picked_level", pending_results[0].level, picked_level);
                if (pending_results[0].keep !== keep_running)
                    note_mismatch("keep_running", pending_results[0].keep, keep_running);
                if (pending_results[0].none !== none_waiting)
                    note_mismatch("none_waiting", pending_results[0].none, none_waiting);
                if (pending_results[0].err !== error_code)
                    note_mismatch("error_code", pending_results[0].err, error_code);
                void'(pending_results.pop_front());
            end
        end
    end

    // watchdog: cycles with neither a request accepted nor a result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        sched_req_t    rq;
        sched_result_t got;
        sent = 0;
        mismatches = 0;
        quiet_cycles = 0;
        last_level = 0;
        last_level_ok = 1'b0;
        tags_waiting = 0;
        for (int lv = 0; lv < NUM_QUEUES; lv++)
        begin
            head_ptr[lv] = 0;
            occupancy[lv] = 0;
        end

        // nothing picked yet, empty queues; then two inserts and a select
        row_given(KIND_CHECK, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  '{1'b0, 16'h0, 3'd0, 1'b0, 1'b1, ERR_OK});
        row_given(KIND_CHECK, 16'h0000, 16'h0005, 16'h0000, 16'h0000,
                  '{1'b0, 16'h0, 3'd0, 1'b0, 1'b1, ERR_OK});
        row_given(KIND_SELECT, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  '{1'b0, 16'h0, 3'd0, 1'b0, 1'b1, ERR_OK});
        row_given(KIND_REQUEUE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                  '{1'b0, 16'h0, 3'd0, 1'b0, 1'b1, ERR_DEMOTE});
        row_given(KIND_INSERT, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  '{1'b0, 16'h0, 3'd0, 1'b0, 1'b0, ERR_OK});
        row_given(KIND_INSERT, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                  '{1'b0, 16'h0, 3'd0, 1'b0, 1'b0, ERR_OK});
        row_given(KIND_SELECT, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                  '{1'b1, 16'h0000, 3'd0, 1'b0, 1'b0, ERR_OK});
        // checks at level 0: sum past 16 bits, exactly finished, within slice
        row_pred(KIND_CHECK, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
        row_given(KIND_CHECK, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
                  '{1'b0, 16'h0, 3'd0, 1'b0, 1'b0, ERR_OK});
        row_pred(KIND_CHECK, 16'h0000, 16'h0010, 16'h0000, 16'h0000, 1);
        // walk one task down every level
        row_pred(KIND_REQUEUE, 16'hA5A5, 16'h0000, 16'h0000, 16'h0000, 1);
        row_pred(KIND_SELECT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 2);
        row_pred(KIND_CHECK, 16'h0000, 16'h0100, 16'h0000, 16'h0001, 1);
        row_pred(KIND_CHECK, 16'h0000, 16'h0100, 16'h0000, 16'h0002, 1);
        row_pred(KIND_REQUEUE, 16'h5A5A, 16'h0000, 16'h0000, 16'h0000, 1);
        row_pred(KIND_SELECT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1);
        row_pred(KIND_REQUEUE, 16'h1234, 16'h0000, 16'h0000, 16'h0000, 1);
        row_pred(KIND_SELECT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1);
        // lowest level keeps running, cannot be demoted further
        row_pred(KIND_CHECK, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1);
        row_given(KIND_REQUEUE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                  '{1'b0, 16'h0, 3'd0, 1'b0, 1'b1, ERR_DEMOTE});
        // fill level 0, overflow it, then drain it
        row_pred(KIND_INSERT, 16'h8000, 16'h0000, 16'h0000, 16'h0000, QUEUE_DEPTH);
        row_given(KIND_INSERT, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000,
                  '{1'b0, 16'h0, 3'd0, 1'b0, 1'b0, ERR_FULL});
        row_pred(KIND_SELECT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, QUEUE_DEPTH + 1);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            for (int k = 0; k < script[i].reps; k++)
            begin
                rq = script[i].req;
                rq.tag = rq.tag + TAG_W'(k);
                issue(rq, script[i].given, script[i].want, got);
            end
        end
        random_traffic(sent + RANDOM_ITEMS);
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mfs_pkg.sv
rtl/mfs_ram.sv
rtl/mfs_front.sv
rtl/mfs_back.sv
rtl/multilevel_feedback_scheduler.sv
verif/tb_multilevel_feedback_scheduler.sv
